// ===== src/psll_pkg.sv =====
// ---------------------------------------------------------------------------
// psll_pkg
// Shared sizes, codes and the result word layout of the pooled linked list.
// ---------------------------------------------------------------------------
`default_nettype none

package psll_pkg;

   // pool size and derived pointer widths
   localparam int NODES    = 1024;
   localparam int IDX_W    = $clog2(NODES);
   localparam int PTR_W    = IDX_W + 1;
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // stream word widths, padded to whole bytes
   localparam int REQ_BITS = MODE_W + IDX_W + VALUE_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STATUS_W + PTR_W + IDX_W + VALUE_W + PTR_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INS_HEAD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_AFTER = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEL_AFTER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_HEAD  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNALLOC = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   // end of list marker
   localparam logic [PTR_W-1:0] LIST_END = '1;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [PTR_W-1:0]    read_link;
      logic [VALUE_W-1:0]  read_value;
      logic [IDX_W-1:0]    new_slot;
      logic [PTR_W-1:0]    head_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/psll_ram.sv =====
// ---------------------------------------------------------------------------
// psll_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module psll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/pooled_singly_linked_list.sv =====
// ---------------------------------------------------------------------------
// pooled_singly_linked_list
// Singly linked list kept in a pool of node slots held in two RAMs.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one word per operation (mode, node_index, value). Modes are
//   insert at head, insert after a node, unlink the node after a node, unlink
//   the head and read a node. rsp channel: exactly one word per request with
//   status, head after the operation, slot taken by an insert and read data.
//   Slots are handed out in order by a bump counter and never reused.
//   Flow: the request is taken in idle and the value and link RAMs are read
//   in that cycle; once the output register is free, the execute state
//   registers the result for insert head, unlink head, read and unused modes.
//   Insert after and unlink after pass one more state (link or unlink): the
//   link RAM has one port each way, so the second link access waits.
//   A finished result sits in the output register; the next request is taken
//   meanwhile, but its result waits until the receiver takes the old one.
//   Reset empties the list and the pool at once; RAM contents need no clear.
// ---------------------------------------------------------------------------
`default_nettype none

module pooled_singly_linked_list (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   // mode, node_index, value, zero pad
   input  wire  [psll_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   // status, head_index, new_slot, read_value, read_link, zero pad
   output logic [psll_pkg::RSP_W-1:0] rsp_tdata
);

   import psll_pkg::*;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_LINK   = 2'd2;
   localparam logic [1:0] S_UNLINK = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   free_ff, free_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               out_free;
   logic               known;
   logic               full;
   logic [MODE_W-1:0]  req_mode;
   logic [IDX_W-1:0]   req_index;

   logic               val_we;
   logic [VALUE_W-1:0] val_rd;
   logic               link_we;
   logic [IDX_W-1:0]   link_wa;
   logic [PTR_W-1:0]   link_wd;
   logic               link_re;
   logic [IDX_W-1:0]   link_ra;
   logic [PTR_W-1:0]   link_rd;
   logic               issue_next;

   // request fields
   assign req_mode  = req_tdata[MODE_W-1:0];
   assign req_index = req_tdata[MODE_W +: IDX_W];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign known      = {1'b0, index_ff} < free_ff;
   assign full       = (free_ff == PTR_W'(NODES));

   // value store
   psll_ram #(.WIDTH(VALUE_W), .DEPTH(NODES)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (free_ff[IDX_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (accept),
      .rd_addr (req_index),
      .rd_data (val_rd)
   );

   // link store
   psll_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // link read address: anchor or head at accept, successor when unlinking
   always_comb begin
      link_re = accept || issue_next;
      if (accept) begin
         link_ra = (req_mode == MODE_DEL_HEAD) ? head_ff[IDX_W-1:0] : req_index;
      end else begin
         link_ra = link_rd[IDX_W-1:0];
      end
   end

   // operation sequencing
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      val_we       = 1'b0;
      link_we      = 1'b0;
      link_wa      = free_ff[IDX_W-1:0];
      link_wd      = link_rd;
      issue_next   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_in            = '0;
               rsp_in.status     = STATUS_OK;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
               unique case (mode_ff)
                  MODE_INS_HEAD: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        val_we          = 1'b1;
                        link_we         = 1'b1;
                        link_wd         = head_ff;
                        head_in         = free_ff;
                        free_in         = free_ff + 1'b1;
                        rsp_in.new_slot = free_ff[IDX_W-1:0];
                     end
                  end
                  MODE_INS_AFTER: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else if (!known) begin
                        rsp_in.status = STATUS_UNALLOC;
                     end else begin
                        // new node takes the anchor's link, anchor relinks next
                        val_we       = 1'b1;
                        link_we      = 1'b1;
                        link_wd      = link_rd;
                        rsp_valid_in = 1'b0;
                        state_in     = S_LINK;
                     end
                  end
                  MODE_DEL_AFTER: begin
                     if (!known) begin
                        rsp_in.status = STATUS_UNALLOC;
                     end else if (link_rd[PTR_W-1]) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        // fetch the successor's link
                        issue_next   = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_UNLINK;
                     end
                  end
                  MODE_DEL_HEAD: begin
                     if (head_ff[PTR_W-1]) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        head_in = link_rd;
                     end
                  end
                  MODE_READ: begin
                     if (!known) begin
                        rsp_in.status = STATUS_UNALLOC;
                     end else begin
                        rsp_in.read_value = val_rd;
                        rsp_in.read_link  = link_rd;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.head_index = head_in;
            end
         end
         S_LINK: begin
            if (out_free) begin
               link_we           = 1'b1;
               link_wa           = index_ff;
               link_wd           = free_ff;
               free_in           = free_ff + 1'b1;
               rsp_in            = '0;
               rsp_in.status     = STATUS_OK;
               rsp_in.new_slot   = free_ff[IDX_W-1:0];
               rsp_in.head_index = head_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_UNLINK: begin
            if (out_free) begin
               link_we           = 1'b1;
               link_wa           = index_ff;
               link_wd           = link_rd;
               rsp_in            = '0;
               rsp_in.status     = STATUS_OK;
               rsp_in.head_index = head_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= LIST_END;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         index_ff <= req_index;
         value_ff <= req_tdata[MODE_W + IDX_W +: VALUE_W];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_ff);

`ifndef SYNTHESIS
   // the bump counter never passes the pool size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= PTR_W'(NODES))
      else $error("slot counter beyond pool size");

   // head is either the end marker or an allocated slot
   a_head_alloc: assert property (@(posedge clock) disable iff (reset)
      head_ff[PTR_W-1] || (head_ff < free_ff))
      else $error("head points at an unallocated slot");

   // link writes only touch allocated slots or the slot being taken
   a_link_write: assert property (@(posedge clock) disable iff (reset)
      link_we |-> ({1'b0, link_wa} <= free_ff))
      else $error("link write beyond allocated slots");

   // an accepted word always goes to execution next
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted word not executed");

   // a result is only produced by a working state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != S_IDLE))
      else $error("result raised from idle");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Streams list operations into the pooled linked list and checks every
// result word against a cycle-free model of the list kept in the bench.
// Directed operations hit the empty list, unallocated slots, unlinked anchors
// and unused modes. Random operations mostly use allocated slots and run
// until the pool is full. Idling on both sides and one long receiver
// hold-off fill and stall the block.
// ---------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import psll_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 500_000;
   localparam int MAX_PRINTS   = 100;

   // clock, reset and block ports
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // stimulus and idling control
   logic [REQ_W-1:0] op_queue [$];
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   bit               hold_go        = 1'b0;
   bit               hold_off       = 1'b0;
   logic             req_taken      = 1'b0;
   int               gen_slots      = 0;

   // list model state
   logic [PTR_W-1:0]   head_ptr;
   logic [PTR_W-1:0]   slots_used;
   logic [VALUE_W-1:0] slot_values [NODES];
   logic [PTR_W-1:0]   slot_links  [NODES];

   // results owed by the block, oldest first
   rsp_type results_due [$];
   int      errors = 0;
   int      ops_done = 0;
   int      words_checked = 0;
   int      status_count [4];

   pooled_singly_linked_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         flag_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // one list operation on the model, returns the result word it owes
   function automatic rsp_type apply_list_op(input logic [MODE_W-1:0] mode,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [VALUE_W-1:0] value);
      rsp_type r;
      bit      known;
      r = '0;
      known = ({1'b0, idx} < slots_used);
      case (mode)
         MODE_INS_HEAD, MODE_INS_AFTER: begin
            if (slots_used >= NODES) begin
               r.status = STATUS_FULL;
            end else if (mode == MODE_INS_AFTER && !known) begin
               r.status = STATUS_UNALLOC;
            end else begin
               r.new_slot = slots_used[IDX_W-1:0];
               slot_values[slots_used[IDX_W-1:0]] = value;
               if (mode == MODE_INS_HEAD) begin
                  slot_links[slots_used[IDX_W-1:0]] = head_ptr;
                  head_ptr = slots_used;
               end else begin
                  slot_links[slots_used[IDX_W-1:0]] = slot_links[idx];
                  slot_links[idx] = slots_used;
               end
               slots_used = slots_used + 1'b1;
            end
         end
         MODE_DEL_AFTER: begin
            if (!known) r.status = STATUS_UNALLOC;
            else if (slot_links[idx] == LIST_END) r.status = STATUS_EMPTY;
            else slot_links[idx] = slot_links[slot_links[idx][IDX_W-1:0]];
         end
         MODE_DEL_HEAD: begin
            if (head_ptr == LIST_END) r.status = STATUS_EMPTY;
            else head_ptr = slot_links[head_ptr[IDX_W-1:0]];
         end
         MODE_READ: begin
            if (!known) begin
               r.status = STATUS_UNALLOC;
            end else begin
               r.read_value = slot_values[idx];
               r.read_link  = slot_links[idx];
            end
         end
         default: ;
      endcase
      r.head_index = head_ptr;
      return r;
   endfunction

   // pack one operation into a request word and track slot allocation
   task automatic queue_op(input logic [MODE_W-1:0] mode, input int idx,
                           input logic [VALUE_W-1:0] value);
      logic [REQ_W-1:0] w;
      w = '0;
      w[MODE_W-1:0]             = mode;
      w[MODE_W +: IDX_W]        = idx[IDX_W-1:0];
      w[MODE_W+IDX_W +: VALUE_W] = value;
      op_queue.push_back(w);
      if ((mode == MODE_INS_HEAD || mode == MODE_INS_AFTER) && gen_slots < NODES &&
          (mode == MODE_INS_HEAD || idx < gen_slots))
         gen_slots++;
   endtask

   // random operation, mostly on allocated slots
   task automatic queue_random_op(output bit ignored);
      int               pick;
      int               idx;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(99);
      ignored = 1'b0;
      if (pick < 35) mode = MODE_INS_HEAD;
      else if (pick < 70) mode = MODE_INS_AFTER;
      else if (pick < 80) mode = MODE_DEL_AFTER;
      else if (pick < 87) mode = MODE_DEL_HEAD;
      else if (pick < 97) mode = MODE_READ;
      else begin
         mode = MODE_W'($urandom_range(7, 5));
         ignored = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 85 && gen_slots > 0) idx = $urandom_range(gen_slots - 1, 0);
      else if (pick < 93 && gen_slots < NODES) idx = $urandom_range(NODES - 1, gen_slots);
      else idx = $urandom_range(NODES - 1);
      queue_op(mode, idx, $urandom());
   endtask

   task automatic queue_random(input int count);
      int n;
      bit ignored;
      n = 0;
      while (n < count) begin
         queue_random_op(ignored);
         if (!ignored) n++;
      end
   endtask

   // wait until every word is sent and every result is back
   task automatic wait_drained();
      do @(negedge clock);
      while (op_queue.size() != 0 || req_tvalid || results_due.size() != 0);
      @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= op_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off, counted here
   initial begin
      wait (hold_go);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin : monitor
      rsp_type due;
      rsp_type got;
      if (reset) begin
         req_taken  <= 1'b0;
         head_ptr   = LIST_END;
         slots_used = '0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            due = apply_list_op(req_tdata[MODE_W-1:0], req_tdata[MODE_W +: IDX_W],
                                req_tdata[MODE_W+IDX_W +: VALUE_W]);
            results_due.push_back(due);
            ops_done++;
            status_count[due.status]++;
         end
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            got = rsp_tdata[RSP_BITS-1:0];
            if (results_due.size() == 0) begin
               flag_error($sformatf("result word 0x%0h with no operation pending",
                                    rsp_tdata));
            end else begin
               due = results_due.pop_front();
               compare_field("status", got.status, due.status);
               compare_field("head_index", got.head_index, due.head_index);
               compare_field("new_slot", got.new_slot, due.new_slot);
               compare_field("read_value", got.read_value, due.read_value);
               compare_field("read_link", got.read_link, due.read_link);
               compare_field("pad", rsp_tdata[RSP_W-1:RSP_BITS], '0);
            end
         end
      end
   end

   // stimulus phases
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: empty list, unallocated slots, extremes, unlinked anchors
      queue_op(MODE_DEL_HEAD, 0, '0);
      queue_op(MODE_READ, 0, '0);
      queue_op(MODE_INS_AFTER, 0, 32'h1234_5678);
      queue_op(MODE_DEL_AFTER, NODES - 1, '0);
      queue_op(MODE_INS_HEAD, 0, 32'h8000_0000);
      queue_op(MODE_DEL_AFTER, 0, '0);
      queue_op(MODE_INS_HEAD, NODES - 1, 32'h7fff_ffff);
      queue_op(MODE_INS_AFTER, 0, 32'hffff_ffff);
      queue_op(MODE_INS_AFTER, 1, 32'h0000_0000);
      queue_op(MODE_READ, 1, '0);
      queue_op(MODE_READ, 3, '0);
      queue_op(MODE_DEL_AFTER, 1, '0);
      queue_op(MODE_READ, 3, '0);
      queue_op(MODE_INS_AFTER, 3, 32'h5555_5555);
      queue_op(MODE_DEL_AFTER, 3, 32'haaaa_aaaa);
      queue_op(3'd5, NODES - 1, 32'haaaa_aaaa);
      queue_op(3'd6, 0, 32'h5555_5555);
      queue_op(3'd7, NODES - 1, 32'hffff_ffff);
      queue_op(MODE_READ, NODES - 1, '0);
      queue_op(MODE_DEL_HEAD, 0, '0);
      queue_op(MODE_DEL_HEAD, 0, '0);
      queue_op(MODE_DEL_HEAD, 0, '0);
      queue_op(MODE_DEL_HEAD, NODES - 1, '0);
      queue_op(MODE_READ, 2, '0);
      queue_op(MODE_READ, 4, '0);
      wait_drained();

      // random, no idling
      queue_random(400);
      wait_drained();

      // sender mostly idle
      send_idle_pct = 79;
      queue_random(300);
      wait_drained();

      // receiver mostly stalled
      send_idle_pct  = 0;
      recv_stall_pct = 79;
      queue_random(300);
      wait_drained();

      // light idling on both sides
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      queue_random(300);
      wait_drained();

      // receiver holds off while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go = 1'b1;
      queue_random(100);
      wait_drained();

      // fill the pool, then keep going with it full
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      while (gen_slots < NODES) queue_random(1);
      queue_random(150);
      wait_drained();

      repeat (20) @(posedge clock);
      $display("%0d operations, %0d result words checked", ops_done, words_checked);
      $display("status ok %0d, full %0d, unallocated %0d, nothing to remove %0d",
               status_count[STATUS_OK], status_count[STATUS_FULL],
               status_count[STATUS_UNALLOC], status_count[STATUS_EMPTY]);
      $display("pool reached %0d of %0d slots, receiver held off once for %0d cycles",
               slots_used, NODES, HOLD_CYCLES);
      if (errors == 0) begin
         $display("pooled_singly_linked_list test passed");
      end else begin
         $display("pooled_singly_linked_list test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("pooled_singly_linked_list test failed");
      $finish;
   end

endmodule
